/* src/circle_sweep_and_prune_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the circle sweep-and-prune core
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_SWEEP_AND_PRUNE_CORE_ASSERT_SVH
`define CIRCLE_SWEEP_AND_PRUNE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CSAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define CSAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/csap_pkg.sv */
// ----------------------------------------------------------------------------
// csap_pkg
// Types, codes and constants shared by the sweep-and-prune core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none
package csap_pkg;

  localparam int MAX_COLLIDERS_DEF = 32;
  localparam int RANK_W = 5;
  localparam int CMP_W = 6;

  // Item kinds
  localparam logic [1:0] KIND_REGISTER = 2'd0;
  localparam logic [1:0] KIND_REMOVE   = 2'd1;
  localparam logic [1:0] KIND_MOVE     = 2'd2;
  localparam logic [1:0] KIND_SWEEP    = 2'd3;

  // Sweep modes
  localparam logic [1:0] MODE_X_ONLY = 2'd0;
  localparam logic [1:0] MODE_DOUBLE = 2'd1;

  // Cell load operations
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_NEW   = 2'd1;
  localparam logic [1:0] OP_LEFT  = 2'd2;
  localparam logic [1:0] OP_RIGHT = 2'd3;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        r;
    logic               seen;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    logic       clr_seen;
  } cell_ctl_t;

  typedef struct packed {
    logic le;
    logic hit;
  } cell_flags_t;

endpackage
`default_nettype wire

/* src/csap_cell.sv */
// ----------------------------------------------------------------------------
// csap_cell
// One table slot: holds an entry, loads from a neighbor or a new entry, and
// reports its compare results against the current key.
// ----------------------------------------------------------------------------
`default_nettype none
module csap_cell (
  input  wire                   clk,
  input  csap_pkg::cell_ctl_t   ctl,
  input  csap_pkg::entry_t      new_ent,
  input  csap_pkg::entry_t      left_ent,
  input  csap_pkg::entry_t      right_ent,
  input  wire                   valid,
  input  wire signed [15:0]     key_x,
  input  wire [15:0]            key_id,
  output csap_pkg::entry_t      ent,
  output csap_pkg::cell_flags_t flags
);
  import csap_pkg::*;

  entry_t ent_next;

  // Select the next slot contents, then drop the seen flag on a pass clear
  always_comb begin
    case (ctl.op)
      OP_NEW:   ent_next = new_ent;
      OP_LEFT:  ent_next = left_ent;
      OP_RIGHT: ent_next = right_ent;
      default:  ent_next = ent;
    endcase
    if (ctl.clr_seen) begin
      ent_next.seen = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

  // Compare against the key of the current item
  assign flags.le  = valid && (ent.x <= key_x);
  assign flags.hit = valid && (ent.id == key_id);

endmodule
`default_nettype wire

/* src/circle_sweep_and_prune_core.sv */
// ----------------------------------------------------------------------------
// circle_sweep_and_prune_core
// Sorted circle table with register, remove, move and sweep items.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. Results appear on
//   collider_index, group_empty, table_full and last_of_group for exactly one
//   cycle while result_valid is high; last_of_group marks the final result of
//   the item. The receiver cannot stall, so results are never held back.
//   The sweep_mode register is written over cfg_valid/cfg_ready/cfg_data,
//   always ready; write it only while busy is low.
//   A register item passes the insert state, a remove the delete state, and a
//   move the delete state and then, if its id was found, the insert state.
//   A sweep rotates the whole row of MAX_COLLIDERS cells once around its ring,
//   one cell per cycle while no id is being emitted and no circle test in
//   modes 1 to 3 (the squaring stage) is pending.
//   Reset (rst, synchronous) empties the table, clears next_id and sets
//   sweep_mode to 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module circle_sweep_and_prune_core #(
  parameter int MAX_COLLIDERS = csap_pkg::MAX_COLLIDERS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire [1:0]         kind,
  input  wire [15:0]        target_id,
  input  wire signed [15:0] pos_x,
  input  wire signed [15:0] pos_y,
  input  wire [14:0]        radius,
  input  wire [4:0]         anchor_rank,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [1:0]         cfg_data,
  output logic              result_valid,
  output logic [16:0]       collider_index,
  output logic              group_empty,
  output logic              table_full,
  output logic              last_of_group
);
  import csap_pkg::*;

  localparam int CNT_W = $clog2(MAX_COLLIDERS + 1);
  localparam int K_W   = $clog2(MAX_COLLIDERS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;

  logic [2:0]        state;
  logic [1:0]        sweep_mode;
  logic [CNT_W-1:0]  count;
  logic [15:0]       next_id;
  logic              is_move;
  logic [15:0]       tid_q;
  logic [RANK_W-1:0] rank_q;
  entry_t            hold_ent;

  // Sweep state
  logic [K_W-1:0]     k;
  logic               active, stopped, a_done, a_seen, sq_ok;
  logic [15:0]        a_id;
  logic signed [15:0] a_x, a_y;
  logic [14:0]        a_r;
  logic signed [17:0] a_right;
  logic [33:0]        dx2, dy2;
  logic [31:0]        rs2;
  logic [16:0]        lst [4];
  logic [2:0]         lst_n;
  logic [1:0]         lst_i;
  logic               set_h, set_t;
  logic               pend_v;
  logic [16:0]        pend;

  // Cell row
  entry_t      ent      [MAX_COLLIDERS];
  entry_t      left_in  [MAX_COLLIDERS];
  entry_t      right_in [MAX_COLLIDERS];
  cell_ctl_t   ctl      [MAX_COLLIDERS];
  cell_flags_t flg      [MAX_COLLIDERS];
  logic [MAX_COLLIDERS-1:0] vld, le_v, hit_v, first_hit, ge_v;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < MAX_COLLIDERS; i++) begin : g_cell
    assign vld[i]   = CNT_W'(i) < count;
    assign le_v[i]  = flg[i].le;
    assign hit_v[i] = flg[i].hit;
    csap_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .new_ent   (hold_ent),
      .left_ent  (left_in[i]),
      .right_ent (right_in[i]),
      .valid     (vld[i]),
      .key_x     (hold_ent.x),
      .key_id    (tid_q),
      .ent       (ent[i]),
      .flags     (flg[i])
    );
  end

  // Lowest matching slot and the slots at or above it
  assign first_hit = hit_v & (~hit_v + MAX_COLLIDERS'(1));
  assign ge_v      = ~(first_hit - MAX_COLLIDERS'(1));

  // Entry at the lowest matching slot
  entry_t taken;
  always_comb begin
    taken = '0;
    for (int i = 0; i < MAX_COLLIDERS; i++) begin
      if (first_hit[i]) begin
        taken = taken | ent[i];
      end
    end
  end

  // Sweep decision on the head cell
  entry_t             head;
  logic               hv, after, brk, cand, need_sq, meet, circ, dbl, rotate;
  logic [CMP_W-1:0]   kk, rk;
  logic signed [17:0] h_left;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic [15:0]        rs;
  logic [16:0]        itm [4];
  logic [2:0]         n_itm;
  logic               sh_n, st_n;

  always_comb begin
    head    = ent[0];
    circ    = (sweep_mode != MODE_X_ONLY);
    dbl     = (sweep_mode == MODE_DOUBLE);
    kk      = CMP_W'(k);
    rk      = CMP_W'(rank_q);
    hv      = CNT_W'(k) < count;
    h_left  = 18'(head.x) - $signed({3'b000, head.r});
    after   = hv && active && !stopped && (kk > rk);
    brk     = h_left > a_right;
    cand    = after && !brk;
    need_sq = cand && circ && !sq_ok;
    dx      = 17'(a_x) - 17'(head.x);
    dy      = 17'(a_y) - 17'(head.y);
    adx     = dx[16] ? 17'(-dx) : 17'(dx);
    ady     = dy[16] ? 17'(-dy) : 17'(dy);
    rs      = {1'b0, a_r} + {1'b0, head.r};
    meet    = (35'(dx2) + 35'(dy2)) <= 35'(rs2);
    n_itm   = '0;
    sh_n    = 1'b0;
    st_n    = 1'b0;
    for (int j = 0; j < 4; j++) begin
      itm[j] = '0;
    end
    if (cand && !circ) begin
      if ((kk == rk + CMP_W'(1)) && !a_seen) begin
        itm[n_itm[1:0]] = {1'b0, a_id};
        n_itm = n_itm + 3'd1;
        st_n = 1'b1;
      end
      if (!head.seen) begin
        itm[n_itm[1:0]] = {1'b0, head.id};
        n_itm = n_itm + 3'd1;
        sh_n = 1'b1;
      end
    end else if (cand && meet) begin
      if (!a_done) begin
        if (dbl) begin
          itm[0] = {a_id, 1'b0};
          itm[1] = {a_id, 1'b1};
          n_itm  = 3'd2;
        end else begin
          itm[0] = {1'b0, a_id};
          n_itm  = 3'd1;
        end
      end
      if (dbl) begin
        itm[n_itm[1:0]] = {head.id, 1'b0};
        itm[n_itm[1:0] + 2'd1] = {head.id, 1'b1};
        n_itm = n_itm + 3'd2;
      end else begin
        itm[n_itm[1:0]] = {1'b0, head.id};
        n_itm = n_itm + 3'd1;
      end
    end
    rotate = ((state == S_STEP) && !need_sq && (n_itm == 3'd0)) ||
             ((state == S_EMIT) && ({1'b0, lst_i} == lst_n - 3'd1));
  end

  // Per-cell control and neighbor wiring
  always_comb begin
    for (int i = 0; i < MAX_COLLIDERS; i++) begin
      left_in[i]  = (i == 0) ? hold_ent : ent[(i + MAX_COLLIDERS - 1) % MAX_COLLIDERS];
      right_in[i] = ent[(i + 1) % MAX_COLLIDERS];
      if (i == MAX_COLLIDERS - 1) begin
        right_in[i].seen = ent[0].seen | (rotate && (state == S_EMIT) && set_h);
      end
      if (i == MAX_COLLIDERS - 2) begin
        right_in[i].seen = ent[i + 1].seen | (rotate && (state == S_EMIT) && set_t);
      end
      ctl[i].op       = OP_HOLD;
      ctl[i].clr_seen = start && !busy && (kind == KIND_SWEEP) &&
                        (sweep_mode == MODE_X_ONLY) && (anchor_rank == '0);
      unique case (state) inside
        S_INS: begin
          if (count != CNT_W'(MAX_COLLIDERS)) begin
            if (le_v[i]) begin
              ctl[i].op = OP_HOLD;
            end else if (i == 0 || le_v[(i + MAX_COLLIDERS - 1) % MAX_COLLIDERS]) begin
              ctl[i].op = OP_NEW;
            end else begin
              ctl[i].op = OP_LEFT;
            end
          end
        end
        S_DEL: begin
          if (ge_v[i]) begin
            ctl[i].op = OP_RIGHT;
          end
        end
        S_STEP, S_EMIT: begin
          if (rotate) begin
            ctl[i].op = OP_RIGHT;
          end
        end
        default: ctl[i].op = OP_HOLD;
      endcase
    end
  end

  // Sequencer, bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sweep_mode   <= MODE_X_ONLY;
      count        <= '0;
      next_id      <= '0;
      result_valid <= 1'b0;
      pend_v       <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        sweep_mode <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            tid_q         <= target_id;
            rank_q        <= anchor_rank;
            is_move       <= (kind == KIND_MOVE);
            hold_ent.id   <= next_id;
            hold_ent.x    <= pos_x;
            hold_ent.y    <= pos_y;
            hold_ent.r    <= radius;
            hold_ent.seen <= 1'b0;
            k             <= '0;
            active        <= 1'b0;
            stopped       <= 1'b0;
            a_done        <= 1'b0;
            sq_ok         <= 1'b0;
            pend_v        <= 1'b0;
            unique case (kind) inside
              KIND_REGISTER:          state <= S_INS;
              KIND_REMOVE, KIND_MOVE: state <= S_DEL;
              default:                state <= S_STEP;
            endcase
          end
        end
        S_INS: begin
          result_valid  <= 1'b1;
          last_of_group <= 1'b1;
          if (count == CNT_W'(MAX_COLLIDERS)) begin
            collider_index <= '0;
            group_empty    <= 1'b1;
            table_full     <= 1'b1;
          end else begin
            count      <= count + CNT_W'(1);
            table_full <= 1'b0;
            if (is_move) begin
              collider_index <= '0;
              group_empty    <= 1'b1;
            end else begin
              collider_index <= {1'b0, next_id};
              group_empty    <= 1'b0;
              next_id        <= next_id + 16'd1;
            end
          end
          state <= S_IDLE;
        end
        S_DEL: begin
          if (|hit_v) begin
            count <= count - CNT_W'(1);
          end
          if ((|hit_v) && is_move) begin
            hold_ent.id   <= taken.id;
            hold_ent.r    <= taken.r;
            hold_ent.seen <= taken.seen;
            state         <= S_INS;
          end else begin
            result_valid   <= 1'b1;
            collider_index <= '0;
            group_empty    <= 1'b1;
            table_full     <= 1'b0;
            last_of_group  <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_STEP: begin
          if (need_sq) begin
            dx2   <= adx * adx;
            dy2   <= ady * ady;
            rs2   <= rs * rs;
            sq_ok <= 1'b1;
          end else begin
            // Capture the anchor as it passes the head
            if (hv && (kk == rk)) begin
              active  <= 1'b1;
              a_id    <= head.id;
              a_x     <= head.x;
              a_y     <= head.y;
              a_r     <= head.r;
              a_seen  <= head.seen;
              a_right <= 18'(head.x) + $signed({3'b000, head.r});
            end
            if (after && brk) begin
              stopped <= 1'b1;
            end
            if (cand && circ && meet) begin
              a_done <= 1'b1;
            end
            sq_ok <= 1'b0;
            if (n_itm != 3'd0) begin
              lst   <= itm;
              lst_n <= n_itm;
              lst_i <= '0;
              set_h <= sh_n;
              set_t <= st_n;
              state <= S_EMIT;
            end else if (k == K_W'(MAX_COLLIDERS - 1)) begin
              state <= S_END;
            end else begin
              k <= k + K_W'(1);
            end
          end
        end
        S_EMIT: begin
          // Push the previous id out and hold this one back
          if (pend_v) begin
            result_valid   <= 1'b1;
            collider_index <= pend;
            group_empty    <= 1'b0;
            table_full     <= 1'b0;
            last_of_group  <= 1'b0;
          end
          pend   <= lst[lst_i];
          pend_v <= 1'b1;
          if (rotate) begin
            if (k == K_W'(MAX_COLLIDERS - 1)) begin
              state <= S_END;
            end else begin
              k     <= k + K_W'(1);
              state <= S_STEP;
            end
          end else begin
            lst_i <= lst_i + 2'd1;
          end
        end
        S_END: begin
          result_valid   <= 1'b1;
          collider_index <= pend_v ? pend : '0;
          group_empty    <= !pend_v;
          table_full     <= 1'b0;
          last_of_group  <= 1'b1;
          pend_v         <= 1'b0;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/csap_checker.sv */
// ----------------------------------------------------------------------------
// csap_checker
// Port-level checks on the sweep-and-prune core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circle_sweep_and_prune_core_assert.svh"
module csap_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        result_valid,
  input wire [16:0] collider_index,
  input wire        group_empty,
  input wire        table_full,
  input wire        last_of_group
);

  // An accepted item keeps the block busy until its last result
  `CSAP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted without going busy")
  // The final result of an item leaves the block idle
  `CSAP_ASSERT_NOW(a_last_idle, result_valid && last_of_group, !busy, "busy after last result")
  // A refused register item emits nothing and ends the item
  `CSAP_ASSERT_NOW(a_full_empty, result_valid && table_full, group_empty && last_of_group,
                   "full result not empty or not last")
  // An empty result carries no id
  `CSAP_ASSERT_NOW(a_empty_zero, result_valid && group_empty, collider_index == 17'd0,
                   "empty result with nonzero id")
  // No result appears while idle unless it ends an item
  `CSAP_ASSERT_NOW(a_idle_quiet, result_valid && !busy, last_of_group,
                   "non-final result while idle")

endmodule

bind circle_sweep_and_prune_core csap_checker u_csap_checker (.*);
`default_nettype wire

/* sim/circle_sweep_and_prune_core_tb.sv */
// ----------------------------------------------------------------------------
// circle_sweep_and_prune_core_tb
// Drives register, remove, move and sweep items into the sweep-and-prune core
// in every sweep mode and compares each result against a local table model.
// ----------------------------------------------------------------------------
`default_nettype none
module circle_sweep_and_prune_core_tb;
  import csap_pkg::*;

  localparam int TABLE_DEPTH = MAX_COLLIDERS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [1:0] MODE_PLAIN  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef struct {
    logic [16:0] idx;
    logic        empty;
    logic        full;
    logic        last;
  } result_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] tid;
    logic [15:0] px;
    logic [15:0] py;
    logic [14:0] rad;
    logic [4:0]  rank;
    logic        known;
    logic [16:0] idx;
    logic        empty;
    logic        full;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] kind = '0;
  logic [15:0] target_id = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [14:0] radius = '0;
  logic [4:0] anchor_rank = '0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_data = '0;
  logic busy, cfg_ready, result_valid, group_empty, table_full, last_of_group;
  logic [16:0] collider_index;

  circle_sweep_and_prune_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .target_id(target_id), .pos_x(pos_x), .pos_y(pos_y), .radius(radius),
    .anchor_rank(anchor_rank), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .result_valid(result_valid),
    .collider_index(collider_index), .group_empty(group_empty),
    .table_full(table_full), .last_of_group(last_of_group)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Model state
  entry_t      tbl [TABLE_DEPTH];
  int          live_count;
  logic [15:0] id_next;
  logic [1:0]  mode_reg;
  result_t     pending_results[$];

  int errors;
  int items_sent;
  int results_seen;
  int sweeps_sent;
  int quiet_cycles;
  logic idle_on;
  logic [3:0] modes_used;

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    $display("mismatch @%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void push_result(input logic [16:0] idx, input logic empty,
                                      input logic full);
    result_t r;
    r.idx = idx; r.empty = empty; r.full = full; r.last = 1'b0;
    pending_results = {pending_results, r};
  endfunction

  // Insert after every entry with equal or smaller x
  function automatic void place_entry(input entry_t e);
    int pos;
    pos = 0;
    while (pos < live_count && tbl[pos].x <= e.x) pos++;
    for (int i = live_count; i > pos; i--) tbl[i] = tbl[i-1];
    tbl[pos] = e;
    live_count++;
  endfunction

  function automatic logic take_entry(input logic [15:0] id, output entry_t e);
    for (int i = 0; i < live_count; i++) begin
      if (tbl[i].id == id) begin
        e = tbl[i];
        for (int j = i; j < live_count - 1; j++) tbl[j] = tbl[j+1];
        live_count--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic circles_overlap(input entry_t a, input entry_t b);
    longint dx, dy, rs;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    rs = longint'(a.r) + longint'(b.r);
    return dx*dx + dy*dy <= rs*rs;
  endfunction

  // Work out the results of one item and advance the model
  function automatic void predict_item(input logic [1:0] k, input logic [15:0] tid,
      input logic [15:0] px, input logic [15:0] py, input logic [14:0] rad,
      input logic [4:0] rank);
    entry_t e;
    int n0;
    int right;
    logic anchor_done;
    n0 = pending_results.size();
    anchor_done = 1'b0;
    case (k)
      KIND_REGISTER: begin
        if (live_count >= TABLE_DEPTH) begin
          push_result('0, 1'b1, 1'b1);
        end else begin
          e.id = id_next; e.x = px; e.y = py; e.r = rad; e.seen = 1'b0;
          place_entry(e);
          push_result({1'b0, id_next}, 1'b0, 1'b0);
          id_next++;
        end
      end
      KIND_REMOVE: begin
        void'(take_entry(tid, e));
      end
      KIND_MOVE: begin
        if (take_entry(tid, e)) begin
          e.x = px; e.y = py;
          place_entry(e);
        end
      end
      default: begin
        if (mode_reg == MODE_X_ONLY && rank == 0)
          for (int j = 0; j < TABLE_DEPTH; j++) tbl[j].seen = 1'b0;
        if (rank < live_count) begin
          right = int'(tbl[rank].x) + int'(tbl[rank].r);
          for (int j = rank + 1; j < live_count; j++) begin
            if (int'(tbl[j].x) - int'(tbl[j].r) > right) break;
            if (mode_reg == MODE_X_ONLY) begin
              if (!anchor_done) begin
                anchor_done = 1'b1;
                if (!tbl[rank].seen) begin
                  tbl[rank].seen = 1'b1;
                  push_result({1'b0, tbl[rank].id}, 1'b0, 1'b0);
                end
              end
              if (!tbl[j].seen) begin
                tbl[j].seen = 1'b1;
                push_result({1'b0, tbl[j].id}, 1'b0, 1'b0);
              end
            end else if (circles_overlap(tbl[rank], tbl[j])) begin
              if (mode_reg == MODE_DOUBLE) begin
                if (!anchor_done) begin
                  anchor_done = 1'b1;
                  push_result({tbl[rank].id, 1'b0}, 1'b0, 1'b0);
                  push_result({tbl[rank].id, 1'b1}, 1'b0, 1'b0);
                end
                push_result({tbl[j].id, 1'b0}, 1'b0, 1'b0);
                push_result({tbl[j].id, 1'b1}, 1'b0, 1'b0);
              end else begin
                if (!anchor_done) begin
                  anchor_done = 1'b1;
                  push_result({1'b0, tbl[rank].id}, 1'b0, 1'b0);
                end
                push_result({1'b0, tbl[j].id}, 1'b0, 1'b0);
              end
            end
          end
        end
      end
    endcase
    if (pending_results.size() == n0) push_result('0, 1'b1, 1'b0);
    pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  // Idle gap on the sending side, skipped during the steady stretch
  task automatic random_gap();
    if (idle_on) begin
      while ($urandom_range(99) < 27) @(negedge clk);
    end
  endtask

  task automatic send_item(input logic [1:0] k, input logic [15:0] tid,
      input logic [15:0] px, input logic [15:0] py, input logic [14:0] rad,
      input logic [4:0] rank);
    @(negedge clk);
    random_gap();
    kind <= k; target_id <= tid; pos_x <= px; pos_y <= py;
    radius <= rad; anchor_rank <= rank; start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(k, tid, px, py, rad, rank);
    items_sent++;
    if (k == KIND_SWEEP) sweeps_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Drain expectations, then let a sweep that emits nothing settle
  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_idle();
    cfg_data <= m; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_reg = m;
    modes_used[m] = 1'b1;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random item, mostly clustered positions so sweeps find partners
  task automatic random_item();
    logic [1:0]  k;
    logic [15:0] tid, px, py;
    logic [14:0] rad;
    int sel;
    sel = $urandom_range(99);
    k = (sel < 35) ? KIND_REGISTER : (sel < 45) ? KIND_REMOVE :
        (sel < 58) ? KIND_MOVE : KIND_SWEEP;
    if ($urandom_range(9) < 8 && live_count > 0)
      tid = tbl[$urandom_range(live_count-1)].id;
    else
      tid = 16'($urandom);
    if ($urandom_range(9) < 8) begin
      px = 16'($signed($urandom_range(1600)) - 800);
      py = 16'($signed($urandom_range(1600)) - 800);
      rad = 15'($urandom_range(300));
    end else begin
      px = 16'($urandom); py = 16'($urandom); rad = 15'($urandom);
    end
    send_item(k, tid, px, py, rad,
              (live_count > 0 && $urandom_range(9) < 8) ?
              5'($urandom_range(live_count-1)) : 5'($urandom));
  endtask

  // Directed table
  row_t rows[$];

  function automatic void add_row(input logic [1:0] k, input logic [15:0] tid,
      input logic [15:0] px, input logic [15:0] py, input logic [14:0] rad,
      input logic [4:0] rank, input logic known, input logic [16:0] idx,
      input logic empty, input logic full);
    row_t r;
    r.kind = k; r.tid = tid; r.px = px; r.py = py; r.rad = rad; r.rank = rank;
    r.known = known; r.idx = idx; r.empty = empty; r.full = full;
    rows = {rows, r};
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_t w;
    if (!rst && result_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", collider_index, '0);
      end else begin
        w = pending_results.pop_front();
        if (collider_index !== w.idx) report_mismatch("collider_index", collider_index, w.idx);
        if (group_empty !== w.empty)
          report_mismatch("group_empty", 17'(group_empty), 17'(w.empty));
        if (table_full !== w.full)
          report_mismatch("table_full", 17'(table_full), 17'(w.full));
        if (last_of_group !== w.last)
          report_mismatch("last_of_group", 17'(last_of_group), 17'(w.last));
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("circle_sweep_and_prune_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    row_t r;
    errors = 0; items_sent = 0; results_seen = 0; sweeps_sent = 0;
    idle_on = 1'b1; modes_used = '0;
    live_count = 0; id_next = '0; mode_reg = MODE_X_ONLY;
    for (int i = 0; i < TABLE_DEPTH; i++) tbl[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty-table cases, field extremes, equal x, overlaps
    add_row(KIND_SWEEP, 0, 0, 0, 0, 0, 1, '0, 1, 0);
    add_row(KIND_REMOVE, 16'hFFFF, 0, 0, 0, 0, 1, '0, 1, 0);
    add_row(KIND_MOVE, 16'h0005, 0, 0, 0, 0, 1, '0, 1, 0);
    add_row(KIND_REGISTER, 0, 16'h8000, 16'h8000, 15'h7FFF, 0, 1, 17'd0, 0, 0);
    add_row(KIND_REGISTER, 0, 16'h7FFF, 16'h7FFF, 15'h7FFF, 0, 1, 17'd1, 0, 0);
    add_row(KIND_REGISTER, 0, 16'h0000, 16'h0000, 15'h0000, 0, 1, 17'd2, 0, 0);
    add_row(KIND_REGISTER, 0, 16'h0000, 16'h0010, 15'h0010, 0, 1, 17'd3, 0, 0);
    add_row(KIND_REGISTER, 0, 16'h0020, 16'hFFF0, 15'h0008, 0, 1, 17'd4, 0, 0);
    add_row(KIND_SWEEP, 0, 0, 0, 0, 0, 0, '0, 0, 0);
    add_row(KIND_SWEEP, 0, 0, 0, 0, 1, 0, '0, 0, 0);
    add_row(KIND_SWEEP, 0, 0, 0, 0, 2, 0, '0, 0, 0);
    add_row(KIND_SWEEP, 0, 0, 0, 0, 5'd31, 1, '0, 1, 0);
    add_row(KIND_MOVE, 16'd2, 16'h0020, 16'h0000, 0, 0, 1, '0, 1, 0);
    add_row(KIND_SWEEP, 0, 0, 0, 0, 0, 0, '0, 0, 0);
    add_row(KIND_REMOVE, 16'd1, 0, 0, 0, 0, 1, '0, 1, 0);
    add_row(KIND_SWEEP, 0, 0, 0, 0, 1, 0, '0, 0, 0);

    foreach (rows[i]) begin
      r = rows[i];
      if (i == 9) write_mode(MODE_DOUBLE);
      if (i == 10) write_mode(MODE_PLAIN);
      if (i == 13) write_mode(MODE_X_ONLY);
      if (r.known) begin
        // Hand-read expectation must agree with the model
        send_item(r.kind, r.tid, r.px, r.py, r.rad, r.rank);
        if (pending_results.size() == 0 ||
            pending_results[pending_results.size()-1].idx !== r.idx ||
            pending_results[pending_results.size()-1].empty !== r.empty ||
            pending_results[pending_results.size()-1].full !== r.full)
          report_mismatch("directed row", 17'(pending_results.size()), r.idx);
      end else begin
        send_item(r.kind, r.tid, r.px, r.py, r.rad, r.rank);
      end
    end

    // Fill the table to force a refused register, then sweep from rank 0 and rank 31
    write_mode(MODE_SPARE);
    while (live_count < TABLE_DEPTH)
      send_item(KIND_REGISTER, 0, 16'($urandom_range(400)), 16'($urandom_range(400)),
                15'($urandom_range(200)), 0);
    send_item(KIND_REGISTER, 0, 0, 0, 0, 0);
    send_item(KIND_SWEEP, 0, 0, 0, 0, 0);
    send_item(KIND_SWEEP, 0, 0, 0, 0, 5'd31);

    // Random phases across every mode, one stretch without idling
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(2'(ph));
      idle_on = (ph != 5);
      repeat (50) random_item();
    end
    idle_on = 1'b1;

    wait_idle();
    $display("covered %0d items (%0d sweeps), %0d results, modes seen %b",
             items_sent, sweeps_sent, results_seen, modes_used);
    if (errors == 0) begin
      $display("circle_sweep_and_prune_core_tb: PASS");
    end else begin
      $display("circle_sweep_and_prune_core_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+src
src/csap_pkg.sv
src/csap_cell.sv
src/circle_sweep_and_prune_core.sv
src/csap_checker.sv
sim/circle_sweep_and_prune_core_tb.sv
